FILE: hdl/jot_pkg.sv
// ----------------------------------------------------------------------------
// jot_pkg
// Shared types and constants of the three-axis jump offset tracker.
// ----------------------------------------------------------------------------
package jot_pkg;

    localparam int WORD_W = 32;
    localparam int TOL_W  = 31;
    localparam int LAT_W  = 16;
    localparam int LIM_W  = 15;
    localparam int TIME_W = 48;
    localparam int GAP_W  = 20;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [2:0][WORD_W-1:0]   offset_vec_t;

    // one output request
    typedef struct packed {
        offset_vec_t offset;
        logic        fin;
    } result_t;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOL_X     = 3'd0,
        CFG_TOL_Y     = 3'd1,
        CFG_TOL_Z     = 3'd2,
        CFG_POLAR_LIM = 3'd3,
        CFG_MAX_GAP   = 3'd4
    } cfg_index_t;

    localparam logic [TOL_W-1:0] TOL_XY_RESET  = 31'd256000;
    localparam logic [TOL_W-1:0] TOL_Z_RESET   = 31'd1024;
    localparam logic [LIM_W-1:0] POLAR_RESET   = 15'd14080;
    localparam logic [GAP_W-1:0] MAX_GAP_RESET = 20'd4000;

endpackage

FILE: hdl/jot_axis.sv
// ----------------------------------------------------------------------------
// jot_axis
// Step test and saturating offset update for one axis.
// ----------------------------------------------------------------------------
module jot_axis (
    input  jot_pkg::word_t           sample,
    input  jot_pkg::word_t           held,
    input  jot_pkg::word_t           offset,
    input  logic [jot_pkg::TOL_W-1:0] tolerance,
    input  logic                     test_en,
    output jot_pkg::word_t           offset_next
);
    import jot_pkg::*;

    logic signed [WORD_W:0]   step;
    logic [WORD_W:0]          step_abs;
    logic signed [WORD_W+1:0] diff;
    word_t                    diff_sat;
    logic                     jump;

    // full-precision step, magnitude always fits 33 bits
    assign step     = {sample[WORD_W-1], sample} - {held[WORD_W-1], held};
    assign step_abs = step[WORD_W] ? (WORD_W+1)'(-step) : step;
    assign diff     = {{2{offset[WORD_W-1]}}, offset} - {step[WORD_W], step};

    always_comb
    begin
        if (diff[WORD_W+1:WORD_W-1] == 3'b000 || diff[WORD_W+1:WORD_W-1] == 3'b111)
        begin
            diff_sat = diff[WORD_W-1:0];
        end
        else if (diff[WORD_W+1])
        begin
            diff_sat = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            diff_sat = {1'b0, {(WORD_W-1){1'b1}}};
        end
    end

    assign jump        = test_en && (step_abs > {2'b00, tolerance});
    assign offset_next = jump ? diff_sat : offset;

endmodule

FILE: hdl/three_axis_jump_offset_tracker.sv
// ----------------------------------------------------------------------------
// three_axis_jump_offset_tracker
// Tracks per-axis jump offsets over a series of three-axis residual samples.
// ----------------------------------------------------------------------------
// Usage
//   input channel (in_valid/in_ready): one request per sample with residuals,
//   latitude, timestamp, heading and last flag
//   output channel (out_valid/out_ready): offset requests; each sample after
//   the first gives the offset of the previous sample, and a sample with
//   last_sample set also gives its own offset with final_result high
//   config port: cfg_wr_en/cfg_index/cfg_data, write only while idle
// Timing
//   a sample waits in the input register; its results land in a two-entry
//   output queue as it leaves, and the queue head register drives the output
//   one sample per cycle while each sample gives at most one result and the
//   receiver keeps up; a sample with two results waits for an empty queue
//   (queue drain rate of one a cycle)
// Reset and stalls
//   reset clears the series state and loads the default register values
//   when the receiver stalls the queue fills and in_ready drops once a
//   sample cannot move on into the queue; nothing is lost
// ----------------------------------------------------------------------------
module three_axis_jump_offset_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    // config port
    input  logic                          cfg_wr_en,
    input  logic [jot_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jot_pkg::TOL_W-1:0]     cfg_data,
    // sample input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  jot_pkg::word_t                residual_x,
    input  jot_pkg::word_t                residual_y,
    input  jot_pkg::word_t                residual_z,
    input  logic signed [jot_pkg::LAT_W-1:0] latitude,
    input  logic [jot_pkg::TIME_W-1:0]    timestamp_ms,
    input  logic                          heading_north,
    input  logic                          last_sample,
    // offset output
    output logic                          out_valid,
    input  logic                          out_ready,
    output jot_pkg::word_t                offset_x,
    output jot_pkg::word_t                offset_y,
    output jot_pkg::word_t                offset_z,
    output logic                          final_result
);
    import jot_pkg::*;

    // configuration registers
    logic [TOL_W-1:0]  tol_reg [3];
    logic [LIM_W-1:0]  polar_lim_reg;
    logic [GAP_W-1:0]  max_gap_reg;

    // input register
    logic                     in_valid_reg;
    offset_vec_t              in_res_reg;
    logic signed [LAT_W-1:0]  in_lat_reg;
    logic [TIME_W-1:0]        in_time_reg;
    logic                     in_north_reg;
    logic                     in_last_reg;

    // series state
    offset_vec_t              held_res_reg;
    logic [LAT_W-1:0]         held_alat_reg;   // |latitude| of held sample
    logic                     held_heading_reg;
    logic [TIME_W-1:0]        held_time_reg;
    logic [TIME_W-1:0]        held_gap_reg;    // |time(held) - time(before held)|
    offset_vec_t              run_reg;
    offset_vec_t              stored_reg;
    logic                     turn_seen_reg;
    logic [1:0]               seen_reg;

    // output queue, slot 0 is the head
    result_t                  slot0_reg, slot1_reg;
    result_t                  slot0_next, slot1_next;
    logic [1:0]               cnt_reg, cnt_next;

    logic                     fire;
    logic                     in_fire;
    logic                     pop;
    logic                     have_held;
    logic                     skip;
    logic                     polar;
    logic                     pair_en;
    logic                     turn;
    logic [2:0]               axis_en;
    offset_vec_t              step_run;
    offset_vec_t              run_next;
    offset_vec_t              stored_next;
    logic                     turn_seen_next;
    logic [1:0]               push_cnt;
    logic [1:0]               cnt_after_pop;
    result_t                  res_a, res_b, head_after_pop;
    logic [TIME_W-1:0]        gap_new;
    logic [LAT_W-1:0]         alat_new;

    // ------------------------------------------------------------------------
    // config writes
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg[0]    <= TOL_XY_RESET;
            tol_reg[1]    <= TOL_XY_RESET;
            tol_reg[2]    <= TOL_Z_RESET;
            polar_lim_reg <= POLAR_RESET;
            max_gap_reg   <= MAX_GAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_TOL_X:     tol_reg[0]    <= cfg_data;
                CFG_TOL_Y:     tol_reg[1]    <= cfg_data;
                CFG_TOL_Z:     tol_reg[2]    <= cfg_data;
                CFG_POLAR_LIM: polar_lim_reg <= cfg_data[LIM_W-1:0];
                CFG_MAX_GAP:   max_gap_reg   <= cfg_data[GAP_W-1:0];
                default:       ;   // unused indexes are ignored
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // input register, refilled in the cycle it drains
    // ------------------------------------------------------------------------
    assign in_ready = !in_valid_reg || fire;
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_res_reg   <= {residual_z, residual_y, residual_x};
            in_lat_reg   <= latitude;
            in_time_reg  <= timestamp_ms;
            in_north_reg <= heading_north;
            in_last_reg  <= last_sample;
        end
    end

    // ------------------------------------------------------------------------
    // pair examination
    // ------------------------------------------------------------------------
    assign have_held = (seen_reg != 2'd0);
    // gap test only once the held sample is third or later
    assign skip      = (seen_reg == 2'd3) && (held_gap_reg > {{(TIME_W-GAP_W){1'b0}}, max_gap_reg});
    assign polar     = held_alat_reg > {1'b0, polar_lim_reg};
    assign pair_en   = have_held && !skip;
    assign axis_en   = {pair_en, pair_en && !polar, pair_en && !polar};
    assign turn      = pair_en && held_heading_reg && !in_north_reg;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        jot_axis u_axis (
            .sample      (in_res_reg[a]),
            .held        (held_res_reg[a]),
            .offset      (run_reg[a]),
            .tolerance   (tol_reg[a]),
            .test_en     (axis_en[a]),
            .offset_next (step_run[a])
        );
    end

    // north-to-south turn: first one stores, later ones restore
    always_comb
    begin
        run_next       = step_run;
        stored_next    = stored_reg;
        turn_seen_next = turn_seen_reg;
        if (turn)
        begin
            if (!turn_seen_reg)
            begin
                stored_next    = step_run;
                turn_seen_next = 1'b1;
            end
            else
            begin
                run_next = stored_reg;
            end
        end
    end

    // ------------------------------------------------------------------------
    // results: previous-sample offset first, then final offset on last sample
    // ------------------------------------------------------------------------
    assign push_cnt = {1'b0, have_held} + {1'b0, in_last_reg};
    assign res_b    = '{offset: run_next, fin: 1'b1};
    assign res_a    = have_held ? result_t'{offset: run_reg, fin: 1'b0} : res_b;

    // room is judged before this cycle's pop, so no ready path runs through
    assign fire = in_valid_reg && ({1'b0, push_cnt} <= (3'd2 - {1'b0, cnt_reg}));
    assign pop  = out_valid && out_ready;

    assign cnt_after_pop  = cnt_reg - {1'b0, pop};
    assign head_after_pop = pop ? slot1_reg : slot0_reg;

    always_comb
    begin
        slot0_next = head_after_pop;
        slot1_next = slot1_reg;
        cnt_next   = cnt_after_pop;
        if (fire)
        begin
            cnt_next = cnt_after_pop + push_cnt;
            if (cnt_after_pop == 2'd0)
            begin
                slot0_next = res_a;
                slot1_next = res_b;
            end
            else if (cnt_after_pop == 2'd1)
            begin
                slot1_next = res_a;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign out_valid    = (cnt_reg != 2'd0);
    assign offset_x     = slot0_reg.offset[0];
    assign offset_y     = slot0_reg.offset[1];
    assign offset_z     = slot0_reg.offset[2];
    assign final_result = slot0_reg.fin;

    // ------------------------------------------------------------------------
    // series state update
    // ------------------------------------------------------------------------
    assign gap_new  = (in_time_reg >= held_time_reg) ? in_time_reg - held_time_reg
                                                     : held_time_reg - in_time_reg;
    assign alat_new = in_lat_reg[LAT_W-1] ? LAT_W'(-in_lat_reg) : in_lat_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_res_reg     <= '0;
            held_alat_reg    <= '0;
            held_heading_reg <= 1'b0;
            held_time_reg    <= '0;
            held_gap_reg     <= '0;
            run_reg          <= '0;
            stored_reg       <= '0;
            turn_seen_reg    <= 1'b0;
            seen_reg         <= 2'd0;
        end
        else if (fire)
        begin
            if (in_last_reg)
            begin
                // end of series: back to a clean start
                held_res_reg     <= '0;
                held_alat_reg    <= '0;
                held_heading_reg <= 1'b0;
                held_time_reg    <= '0;
                held_gap_reg     <= '0;
                run_reg          <= '0;
                stored_reg       <= '0;
                turn_seen_reg    <= 1'b0;
                seen_reg         <= 2'd0;
            end
            else
            begin
                held_res_reg     <= in_res_reg;
                held_alat_reg    <= alat_new;
                held_heading_reg <= in_north_reg;
                held_time_reg    <= in_time_reg;
                held_gap_reg     <= gap_new;
                run_reg          <= run_next;
                stored_reg       <= stored_next;
                turn_seen_reg    <= turn_seen_next;
                if (seen_reg != 2'd3)
                begin
                    seen_reg <= seen_reg + 2'd1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output queue over two entries");

    a_series_end: assert property (@(posedge clk) disable iff (!rst_n)
        fire && in_last_reg |=> seen_reg == 2'd0 && !turn_seen_reg)
        else $error("series state not cleared after last sample");

    a_turn_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        turn_seen_reg && !(fire && in_last_reg) |=> turn_seen_reg)
        else $error("turn flag dropped inside a series");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 && !pop |=> cnt_reg == 2'd2 && $stable(slot0_reg))
        else $error("full queue changed without a pop");

endmodule

FILE: sim/jot_offset_checker.sv
// ----------------------------------------------------------------------------
// jot_offset_checker
// Watches the sample, offset and register ports of the jump offset tracker,
// predicts every offset request from the accepted samples and compares each
// accepted offset request against the oldest prediction.
// ----------------------------------------------------------------------------
module jot_offset_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [jot_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [jot_pkg::TOL_W-1:0]        cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  jot_pkg::word_t                   residual_x,
    input  jot_pkg::word_t                   residual_y,
    input  jot_pkg::word_t                   residual_z,
    input  logic signed [jot_pkg::LAT_W-1:0] latitude,
    input  logic [jot_pkg::TIME_W-1:0]       timestamp_ms,
    input  logic                             heading_north,
    input  logic                             last_sample,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  jot_pkg::word_t                   offset_x,
    input  jot_pkg::word_t                   offset_y,
    input  jot_pkg::word_t                   offset_z,
    input  logic                             final_result,
    output int                               fail_count,
    output int                               expected_left,
    output int                               results_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    import jot_pkg::*;

    typedef struct packed {
        word_t x;
        word_t y;
        word_t z;
        logic  fin;
    } offset_result_t;

    offset_result_t offset_queue[$];

    // register copies
    logic [TOL_W-1:0]  tol [3];
    logic [LIM_W-1:0]  polar_lim;
    logic [GAP_W-1:0]  gap_lim;

    // series state
    word_t                   prev_res [3];
    logic signed [LAT_W-1:0] prev_lat;
    logic                    prev_north;
    logic [TIME_W-1:0]       prev_time [2];
    word_t                   track_off [3];
    word_t                   turn_off [3];
    logic                    turn_stored;
    logic [1:0]              series_count;

    function automatic word_t clamp_word(longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return word_t'(v);
    endfunction

    task automatic clear_series();
        for (int a = 0; a < 3; a++)
        begin
            prev_res[a]  = '0;
            track_off[a] = '0;
            turn_off[a]  = '0;
        end
        prev_lat     = '0;
        prev_north   = 1'b0;
        prev_time[0] = '0;
        prev_time[1] = '0;
        turn_stored  = 1'b0;
        series_count = '0;
    endtask

    task automatic predict_offsets();
        word_t             res [3];
        logic              skip;
        logic [TIME_W-1:0] gap;
        int                abs_lat;
        logic              polar;
        longint            step;
        longint            step_mag;

        res[0] = residual_x;
        res[1] = residual_y;
        res[2] = residual_z;
        if (series_count != 0)
        begin
            offset_queue.push_back('{track_off[0], track_off[1], track_off[2], 1'b0});
            skip = 1'b0;
            if (series_count == 2'd3)
            begin
                gap = (prev_time[0] >= prev_time[1]) ? prev_time[0] - prev_time[1]
                                                     : prev_time[1] - prev_time[0];
                if (gap > TIME_W'(gap_lim))
                    skip = 1'b1;
            end
            if (!skip)
            begin
                abs_lat = (prev_lat < 0) ? -int'(prev_lat) : int'(prev_lat);
                polar   = abs_lat > int'(polar_lim);
                for (int a = 0; a < 3; a++)
                begin
                    step     = longint'(res[a]) - longint'(prev_res[a]);
                    step_mag = (step < 0) ? -step : step;
                    if (step_mag > longint'(tol[a]) && !(a < 2 && polar))
                        track_off[a] = clamp_word(longint'(track_off[a]) - step);
                end
                // north to south turn: first one stores, later ones restore
                if (prev_north && !heading_north)
                begin
                    if (!turn_stored)
                    begin
                        turn_off    = track_off;
                        turn_stored = 1'b1;
                    end
                    else
                        track_off = turn_off;
                end
            end
        end
        if (last_sample)
        begin
            offset_queue.push_back('{track_off[0], track_off[1], track_off[2], 1'b1});
            clear_series();
        end
        else
        begin
            prev_res     = res;
            prev_lat     = latitude;
            prev_north   = heading_north;
            prev_time[1] = prev_time[0];
            prev_time[0] = timestamp_ms;
            if (series_count != 2'd3)
                series_count = series_count + 2'd1;
        end
    endtask

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            fail_count++;
            $display("%0t: mismatch on %s: expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol[0]    = TOL_XY_RESET;
            tol[1]    = TOL_XY_RESET;
            tol[2]    = TOL_Z_RESET;
            polar_lim = POLAR_RESET;
            gap_lim   = MAX_GAP_RESET;
            clear_series();
            offset_queue.delete();
            fail_count      = 0;
            expected_left   = 0;
            results_checked = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                results_checked++;
                if (offset_queue.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: offset request with nothing expected: %0d %0d %0d fin %0b",
                             $time, offset_x, offset_y, offset_z, final_result);
                end
                else
                begin
                    offset_result_t want;
                    want = offset_queue.pop_front();
                    check_field("offset_x", want.x, offset_x);
                    check_field("offset_y", want.y, offset_y);
                    check_field("offset_z", want.z, offset_z);
                    check_field("final_result", want.fin, final_result);
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_TOL_X:     tol[0]    = cfg_data;
                    CFG_TOL_Y:     tol[1]    = cfg_data;
                    CFG_TOL_Z:     tol[2]    = cfg_data;
                    CFG_POLAR_LIM: polar_lim = cfg_data[LIM_W-1:0];
                    CFG_MAX_GAP:   gap_lim   = cfg_data[GAP_W-1:0];
                    default:       ;
                endcase
            end
            if (in_valid && in_ready)
                predict_offsets();
            expected_left = offset_queue.size();
        end
    end

endmodule

FILE: sim/tb_three_axis_jump_offset_tracker.sv
// ----------------------------------------------------------------------------
// tb_three_axis_jump_offset_tracker
// Drives sample series into the jump offset tracker: a directed set for
// saturation, turns, time gaps, polar latitude and end of series, then random
// series under eight register settings and four idle mixes. A separate
// checker predicts and compares the offsets; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_three_axis_jump_offset_tracker;

    timeunit 1ns;
    timeprecision 1ps;

    import jot_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int SETTLE       = 8;
    localparam int LONG_HOLD    = 400;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 60;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LAT_MAX      = 23040;

    localparam word_t W_MAX = 32'sh7FFF_FFFF;
    localparam word_t W_MIN = 32'sh8000_0000;
    localparam logic [TIME_W-1:0] T_MAX = '1;

    typedef struct {
        word_t                   x;
        word_t                   y;
        word_t                   z;
        logic signed [LAT_W-1:0] lat;
        logic [TIME_W-1:0]       t;
        logic                    north;
        logic                    last;
    } sample_t;

    // block ports, inputs known from time zero
    logic                    clk           = 1'b0;
    logic                    rst_n         = 1'b0;
    logic                    cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index     = '0;
    logic [TOL_W-1:0]        cfg_data      = '0;
    logic                    in_valid      = 1'b0;
    logic                    in_ready;
    word_t                   residual_x    = '0;
    word_t                   residual_y    = '0;
    word_t                   residual_z    = '0;
    logic signed [LAT_W-1:0] latitude      = '0;
    logic [TIME_W-1:0]       timestamp_ms  = '0;
    logic                    heading_north = 1'b0;
    logic                    last_sample   = 1'b0;
    logic                    out_valid;
    logic                    out_ready     = 1'b0;
    word_t                   offset_x;
    word_t                   offset_y;
    word_t                   offset_z;
    logic                    final_result;

    // from the checker
    int fail_count;
    int expected_left;
    int results_checked;

    // stimulus control
    int   send_idle_pct   = 0;
    int   recv_stall_pct  = 0;
    logic long_hold_req   = 1'b0;
    logic long_hold_taken = 1'b0;
    int   hold_left       = 0;
    int   cycle_count     = 0;
    int   samples_sent    = 0;
    int   phase_items     = 0;
    int   settings_used   = 0;

    // register values as last written, used to aim the random steps
    logic [TOL_W-1:0] cur_tol [3];
    logic [LIM_W-1:0] cur_polar;
    logic [GAP_W-1:0] cur_gap;

    // idle mixes: none, sender idle, receiver stalling, both lightly
    int idle_by_mode  [4] = '{0, 77, 0, 16};
    int stall_by_mode [4] = '{0, 0, 77, 16};

    three_axis_jump_offset_tracker DUT (.*);

    jot_offset_checker u_checker (.*);

    always #(CLK_HALF) clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d offsets still expected",
                     cycle_count, expected_left);
            $display("** three_axis_jump_offset_tracker: FAILED **");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (long_hold_req && !long_hold_taken)
        begin
            hold_left       = LONG_HOLD;
            long_hold_taken = 1'b1;
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // offer one sample request; returns at the accepting edge with valid still high
    task automatic send_sample(input sample_t s);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        residual_x    <= s.x;
        residual_y    <= s.y;
        residual_z    <= s.z;
        latitude      <= s.lat;
        timestamp_ms  <= s.t;
        heading_north <= s.north;
        last_sample   <= s.last;
        in_valid      <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
        phase_items++;
    endtask

    // drop valid, then wait until every expected offset has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_left != 0)
            @(negedge clk);
        // the block may still hold a first sample that gives no result
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [TOL_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_TOL_X:     cur_tol[0] = val;
            CFG_TOL_Y:     cur_tol[1] = val;
            CFG_TOL_Z:     cur_tol[2] = val;
            CFG_POLAR_LIM: cur_polar  = val[LIM_W-1:0];
            CFG_MAX_GAP:   cur_gap    = val[GAP_W-1:0];
            default:       ;
        endcase
    endtask

    function automatic logic [TOL_W-1:0] rand_tolerance();
        case ($urandom_range(0, 3))
            0:       return TOL_W'($urandom_range(0, 3000));
            1:       return TOL_W'($urandom_range(0, 600000));
            2:       return TOL_W'($urandom);
            default: return TOL_XY_RESET;
        endcase
    endfunction

    // setting 0 is all low, setting 1 has all-ones tolerances and wide limits, the rest random
    task automatic apply_setting(input int which);
        logic [TOL_W-1:0] t0, t1, t2, lim, gap;
        case (which)
            0:
            begin
                t0 = '0; t1 = '0; t2 = '0; lim = '0; gap = '0;
            end
            1:
            begin
                t0 = '1; t1 = '1; t2 = '1;
                lim = TOL_W'(LAT_MAX);
                gap = TOL_W'(1000000);
            end
            default:
            begin
                t0  = rand_tolerance();
                t1  = rand_tolerance();
                t2  = rand_tolerance();
                lim = TOL_W'($urandom_range(0, LAT_MAX));
                gap = ($urandom_range(0, 3) == 0) ? TOL_W'($urandom_range(0, 1000000))
                                                  : TOL_W'($urandom_range(0, 10000));
            end
        endcase
        cfg_write(CFG_TOL_X, t0);
        cfg_write(CFG_TOL_Y, t1);
        cfg_write(CFG_TOL_Z, t2);
        cfg_write(CFG_POLAR_LIM, lim);
        cfg_write(CFG_MAX_GAP, gap);
        settings_used++;
    endtask

    // next residual of a series: small wander, clear jump, boundary step or anything
    function automatic word_t next_residual(word_t prev, logic [TOL_W-1:0] tol);
        longint lim;
        longint d;
        lim = longint'(tol);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: d = longint'($urandom_range(0, tol)) - lim / 2;
            5, 6, 7:       d = lim + 1 + longint'($urandom_range(0, 100000));
            8:             d = lim + longint'($urandom_range(0, 1));
            default:       return word_t'($urandom);
        endcase
        if ($urandom_range(0, 1) == 1)
            d = -d;
        return word_t'(longint'(prev) + d);
    endfunction

    // latitude mostly inside the limit, sometimes polar, sometimes on the limit
    function automatic logic signed [LAT_W-1:0] pick_latitude();
        int lim;
        int mag;
        lim = int'(cur_polar);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: mag = $urandom_range(0, lim);
            6, 7, 8:          mag = $urandom_range((lim < LAT_MAX) ? lim + 1 : LAT_MAX, LAT_MAX);
            default:          mag = lim + $urandom_range(0, 1);
        endcase
        if (mag > LAT_MAX)
            mag = LAT_MAX;
        if ($urandom_range(0, 1) == 1)
            mag = -mag;
        return LAT_W'(mag);
    endfunction

    // next timestamp: mostly within the gap limit, sometimes just past it,
    // backwards, or anywhere
    function automatic logic [TIME_W-1:0] next_time(logic [TIME_W-1:0] prev);
        longint g;
        g = longint'(cur_gap);
        case ($urandom_range(0, 19))
            15, 16, 17: return prev + TIME_W'(g + 1 + longint'($urandom_range(0, 1000)));
            18:         return prev - TIME_W'($urandom_range(0, 2 * cur_gap + 2));
            19:         return TIME_W'({$urandom, $urandom});
            default:    return prev + TIME_W'($urandom_range(0, cur_gap));
        endcase
    endfunction

    // one well-formed series with random content; a few are left open
    task automatic run_series();
        sample_t s;
        int      len;
        logic    closes;
        len    = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
        closes = ($urandom_range(0, 9) != 0);
        s.x     = word_t'($urandom);
        s.y     = word_t'($urandom);
        s.z     = word_t'($urandom);
        s.t     = TIME_W'({$urandom, $urandom});
        s.north = 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++)
        begin
            if (i > 0)
            begin
                s.x = next_residual(s.x, cur_tol[0]);
                s.y = next_residual(s.y, cur_tol[1]);
                s.z = next_residual(s.z, cur_tol[2]);
                s.t = next_time(s.t);
                if ($urandom_range(0, 3) == 0)
                    s.north = ~s.north;
            end
            s.lat  = pick_latitude();
            s.last = (i == len - 1) && closes;
            send_sample(s);
        end
    endtask

    // a short burst of unrelated samples
    task automatic noise_burst();
        sample_t s;
        int      n;
        n = $urandom_range(1, 4);
        repeat (n)
        begin
            s.x     = word_t'($urandom);
            s.y     = word_t'($urandom);
            s.z     = word_t'($urandom);
            s.lat   = LAT_W'($urandom_range(0, 2 * LAT_MAX) - LAT_MAX);
            s.t     = TIME_W'({$urandom, $urandom});
            s.north = 1'($urandom_range(0, 1));
            s.last  = ($urandom_range(0, 4) == 0);
            send_sample(s);
        end
    endtask

    function automatic sample_t mk(word_t x, word_t y, word_t z, int lat,
                                   logic [TIME_W-1:0] t, logic north, logic last);
        sample_t s;
        s.x     = x;
        s.y     = y;
        s.z     = z;
        s.lat   = LAT_W'(lat);
        s.t     = t;
        s.north = north;
        s.last  = last;
        return s;
    endfunction

    initial
    begin
        sample_t directed [$];

        cur_tol[0] = TOL_XY_RESET;
        cur_tol[1] = TOL_XY_RESET;
        cur_tol[2] = TOL_Z_RESET;
        cur_polar  = POLAR_RESET;
        cur_gap    = MAX_GAP_RESET;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // lone sample that is also the last of its series
        directed.push_back(mk(W_MAX, W_MIN, W_MAX, LAT_MAX, T_MAX, 1'b1, 1'b1));
        // full-scale steps saturate both ways, then first turn stores
        directed.push_back(mk(W_MAX, W_MIN, 0, 0, 0, 1'b1, 1'b0));
        directed.push_back(mk(W_MIN, W_MAX, 2000, -14080, 4000, 1'b0, 1'b0));
        // latitude exactly on the limit still counts x and y
        directed.push_back(mk(W_MAX, W_MIN, 2000, 14081, 8000, 1'b1, 1'b0));
        // polar held sample, z step equal to tolerance, second turn restores
        directed.push_back(mk(0, 0, 3024, 0, 12001, 1'b0, 1'b0));
        // gap one past the limit: pair skipped
        directed.push_back(mk(W_MIN, W_MAX, 4049, -LAT_MAX, 12002, 1'b1, 1'b0));
        directed.push_back(mk(W_MAX, W_MIN, W_MIN, 0, 12003, 1'b0, 1'b0));
        // time runs backwards, absolute gap
        directed.push_back(mk(0, 0, W_MAX, 100, 0, 1'b1, 1'b0));
        directed.push_back(mk(W_MIN, W_MIN, 0, -100, 1, 1'b0, 1'b1));
        // two-sample series with a turn
        directed.push_back(mk(1000, -1000, 0, 0, T_MAX, 1'b1, 1'b0));
        directed.push_back(mk(-300000, 300000, -1025, 0, T_MAX, 1'b0, 1'b1));
        // timestamps at both ends of the range
        directed.push_back(mk(0, 0, 0, 0, T_MAX, 1'b0, 1'b0));
        directed.push_back(mk(256001, -256001, 1025, 0, 0, 1'b1, 1'b0));
        directed.push_back(mk(0, 0, 0, LAT_MAX, 10, 1'b0, 1'b0));
        directed.push_back(mk(W_MAX, W_MAX, W_MAX, 0, 20, 1'b1, 1'b1));
        // series with no turn, south all the way, several jumps
        directed.push_back(mk(5, 5, 5, -LAT_MAX, 100, 1'b0, 1'b0));
        directed.push_back(mk(-256000, 256000, 1029, 0, 200, 1'b0, 1'b0));
        directed.push_back(mk(300000, -300000, -5000, 0, 300, 1'b0, 1'b0));
        directed.push_back(mk(0, 0, 0, 0, 400, 1'b0, 1'b1));

        foreach (directed[i])
            send_sample(directed[i]);
        drain_results();

        // indexes past the last register must leave everything alone
        for (int k = int'(CFG_MAX_GAP) + 1; k < (1 << CFG_IDX_W); k++)
            cfg_write(CFG_IDX_W'(k), TOL_W'($urandom));

        for (int p = 0; p < PHASES; p++)
        begin
            logic pressure_done;
            drain_results();
            apply_setting(p);
            send_idle_pct  = idle_by_mode[p % 4];
            recv_stall_pct = stall_by_mode[p % 4];
            phase_items    = 0;
            pressure_done  = 1'b0;
            while (phase_items < PHASE_ITEMS)
            begin
                if (!pressure_done && phase_items >= 20)
                begin
                    pressure_done = 1'b1;
                    // long receiver hold-off while samples keep coming
                    if (p == 0)
                        long_hold_req = 1'b1;
                    // sender pauses until every offset is back
                    else if (p == 5)
                        drain_results();
                end
                if ($urandom_range(0, 6) == 0)
                    noise_burst();
                else
                    run_series();
            end
        end

        drain_results();

        $display("covered %0d samples under %0d register settings and four idle mixes,",
                 samples_sent, settings_used);
        $display("with %0d offset requests compared field by field", results_checked);
        if (fail_count == 0 && expected_left == 0)
            $display("** three_axis_jump_offset_tracker: PASSED **");
        else
            $display("** three_axis_jump_offset_tracker: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
hdl/jot_pkg.sv
hdl/jot_axis.sv
hdl/three_axis_jump_offset_tracker.sv
sim/jot_offset_checker.sv
sim/tb_three_axis_jump_offset_tracker.sv
